>>> rtl/core/perlin_noise_2d_octaves_macros.svh
// Assertion macros used by the noise generator top level.
`ifndef PERLIN_NOISE_2D_OCTAVES_MACROS_SVH
`define PERLIN_NOISE_2D_OCTAVES_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define PN2_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("noise generator check failed");
// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define PN2_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("noise generator check failed");
`else
`define PN2_ASSERT_IMP(lbl, pre, post)
`define PN2_ASSERT_NXT(lbl, pre, post)
`endif

`endif

>>> rtl/core/pn2_pkg.sv
// Types, constants and helper functions of the multi-octave noise generator.
package pn2_pkg;

  localparam int unsigned PN2_MAX_OCTAVES = 8;
  localparam int unsigned PN2_ANGLE_BITS  = 8;
  localparam int unsigned PN2_CELL_LAT    = 10;
  localparam int unsigned PN2_TOT_W       = 40;

  localparam logic [2:0] REG_MULT1      = 3'd0;
  localparam logic [2:0] REG_MULT2      = 3'd1;
  localparam logic [2:0] REG_MULT3      = 3'd2;
  localparam logic [2:0] REG_BASE_FREQ  = 3'd3;
  localparam logic [2:0] REG_FREQ_RATIO = 3'd4;
  localparam logic [2:0] REG_AMP_RATIO  = 3'd5;
  localparam logic [2:0] REG_OCT_COUNT  = 3'd6;
  localparam logic [2:0] REG_AMP_RECIP  = 3'd7;

  localparam logic [16:0] AMP_ONE = 17'h10000;

  typedef struct packed {
    logic [31:0] mult1;
    logic [31:0] mult2;
    logic [31:0] mult3;
    logic [23:0] base_freq;
    logic [15:0] freq_ratio;
    logic [15:0] amp_ratio;
    logic [3:0]  oct_cnt;
    logic [19:0] amp_recip;
  } pn2_cfg_t;

  // Per-request data that travels down the chain of octave cells.
  typedef struct packed {
    logic signed [31:0]          px;
    logic signed [31:0]          py;
    logic [23:0]                 freq;
    logic [16:0]                 amp;
    logic signed [PN2_TOT_W-1:0] total;
  } pn2_side_t;

  function automatic logic [31:0] pn2_rotl16(logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  function automatic int pn2_to_q15(longint v);
    longint vv;
    longint r;
    vv = (v < 0) ? 64'sd0 : v;
    r  = (vv + 64'sd16384) >>> 15;
    return (r > 64'sd32767) ? 32767 : int'(r);
  endfunction

  // One gradient entry: cos in the upper half, sin in the lower half, Q1.15.
  // Only evaluated at elaboration with constant arguments.
  function automatic logic [31:0] pn2_grad_entry(int unsigned k, int unsigned abits);
    longint unsigned p, q, r, rr;
    longint unsigned t, t2, t3, t4, t5, t6, t7, t8;
    longint sv, cv;
    int c0, s0, c, s, oc, os;
    p  = (longint'(k) << (16 - abits)) & 64'hFFFF;
    q  = p >> 14;
    r  = p & 64'h3FFF;
    rr = (r > 64'd8192) ? (64'd16384 - r) : r;
    t  = rr * 64'd102944;
    t2 = (t * t) >> 30;
    t3 = (t2 * t) >> 30;
    t4 = (t2 * t2) >> 30;
    t5 = (t4 * t) >> 30;
    t6 = (t4 * t2) >> 30;
    t7 = (t6 * t) >> 30;
    t8 = (t4 * t4) >> 30;
    sv = longint'(t) - longint'(t3 / 6) + longint'(t5 / 120) - longint'(t7 / 5040);
    cv = 64'sd1073741824 - longint'(t2 / 2) + longint'(t4 / 24)
       - longint'(t6 / 720) + longint'(t8 / 40320);
    c0 = pn2_to_q15(cv);
    s0 = pn2_to_q15(sv);
    if (r > 64'd8192) begin
      c = s0;
      s = c0;
    end else begin
      c = c0;
      s = s0;
    end
    case (q)
      64'd0: begin oc = c;  os = s;  end
      64'd1: begin oc = -s; os = c;  end
      64'd2: begin oc = -c; os = -s; end
      default: begin oc = s; os = -c; end
    endcase
    return {16'(oc), 16'(os)};
  endfunction

endpackage

>>> rtl/core/pn2_if.sv
// Handshake interfaces for point requests, noise results and register writes.
interface pn2_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface pn2_noise_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

interface pn2_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/pn2_cell.sv
// One octave cell: ten-stage pipeline that adds one octave of noise to the running total when active.
module pn2_cell import pn2_pkg::*; #(
  parameter int unsigned ANGLE_BITS = PN2_ANGLE_BITS,
  parameter int unsigned OCT_IDX    = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  pn2_cfg_t  cfg_i,
  input  logic      valid_i,
  input  pn2_side_t side_i,
  output logic      valid_o,
  output pn2_side_t side_o
);

  localparam int unsigned TBL = 1 << ANGLE_BITS;

  typedef struct packed {
    logic [15:0] fx;
    logic [15:0] fy;
    logic [16:0] sx;
    logic [16:0] sy;
  } wt_t;

  logic [31:0] grad_rom [TBL];

  for (genvar k = 0; k < TBL; k++) begin : g_rom
    assign grad_rom[k] = pn2_grad_entry(k, ANGLE_BITS);
  end

  logic [PN2_CELL_LAT-1:0] vld_q;
  pn2_side_t side_q [PN2_CELL_LAT];

  // Corner c: bit 0 selects x0/x1, bit 1 selects y0/y1.
  logic signed [56:0] ux_q, uy_q, ux_d, uy_d;
  logic [31:0] a_q [2], y_q [2], a_d [2], y_d [2], a3_q [2];
  logic [15:0] fx2_q, fy2_q, w2x_q, w2y_q, w2x_d, w2y_d;
  logic [31:0] wwx, wwy;
  logic [33:0] spx, spy;
  wt_t         wt_q [5];
  wt_t         wt_d;
  logic [31:0] b_q [4], b_d [4], h_q [4], h_d [4], g_q [4], g_d [4];
  logic signed [33:0] d_q [4], d_d [4];
  logic signed [16:0] dx [4], dy [4];
  logic signed [52:0] pt_q, pb_q, pt_d, pb_d, pv_q, pv_d;
  logic signed [33:0] d0_q, d2_q, top_d, bot_d, top_q, v_d;
  logic signed [51:0] cv_q, cv_d;
  logic signed [35:0] contrib;
  logic               act;
  logic [39:0]        fprod;
  logic [32:0]        aprod;
  pn2_side_t          last_d;

  always_comb begin
    ux_d = side_i.px * $signed({1'b0, side_i.freq});
    uy_d = side_i.py * $signed({1'b0, side_i.freq});

    y_d[0] = {{7{uy_q[56]}}, uy_q[56:32]};
    y_d[1] = y_d[0] + 32'd1;
    a_d[0] = {{7{ux_q[56]}}, ux_q[56:32]} * cfg_i.mult1;
    a_d[1] = ({{7{ux_q[56]}}, ux_q[56:32]} + 32'd1) * cfg_i.mult1;
    wwx    = ux_q[31:16] * ux_q[31:16];
    wwy    = uy_q[31:16] * uy_q[31:16];
    w2x_d  = wwx[31:16];
    w2y_d  = wwy[31:16];

    spx     = (18'd196608 - {1'b0, fx2_q, 1'b0}) * w2x_q;
    spy     = (18'd196608 - {1'b0, fy2_q, 1'b0}) * w2y_q;
    wt_d.fx = fx2_q;
    wt_d.fy = fy2_q;
    wt_d.sx = spx[32:16];
    wt_d.sy = spy[32:16];

    for (int c = 0; c < 4; c++) begin
      b_d[c] = (y_q[c[1]] ^ pn2_rotl16(a_q[c[0]])) * cfg_i.mult2;
      h_d[c] = (a3_q[c[0]] ^ pn2_rotl16(b_q[c])) * cfg_i.mult3;
      g_d[c] = grad_rom[h_q[c][31 -: ANGLE_BITS]];
      dx[c]  = $signed({c[0], wt_q[2].fx});
      dy[c]  = $signed({c[1], wt_q[2].fy});
      d_d[c] = dx[c] * $signed(g_q[c][31:16]) + dy[c] * $signed(g_q[c][15:0]);
    end

    pt_d = (d_q[1] - d_q[0]) * $signed({1'b0, wt_q[3].sx});
    pb_d = (d_q[3] - d_q[2]) * $signed({1'b0, wt_q[3].sx});

    top_d = d0_q + 34'(pt_q >>> 16);
    bot_d = d2_q + 34'(pb_q >>> 16);
    pv_d  = (bot_d - top_d) * $signed({1'b0, wt_q[4].sy});

    v_d  = top_q + 34'(pv_q >>> 16);
    cv_d = v_d * $signed({1'b0, side_q[7].amp});

    // Octaves beyond the configured count leave the total untouched.
    act     = 5'(OCT_IDX) < {1'b0, cfg_i.oct_cnt};
    contrib = 36'(cv_q >>> 16);
    fprod   = side_q[8].freq * cfg_i.freq_ratio;
    aprod   = side_q[8].amp * cfg_i.amp_ratio;
    last_d  = side_q[8];
    if (act) begin
      last_d.total = side_q[8].total + {{(PN2_TOT_W - 36){contrib[35]}}, contrib};
    end
    last_d.freq = (|fprod[39:36]) ? 24'hFFFFFF : fprod[35:12];
    last_d.amp  = aprod[32:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[PN2_CELL_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < PN2_CELL_LAT - 1; s++) begin
        side_q[s] <= side_q[s-1];
      end
      side_q[PN2_CELL_LAT-1] <= last_d;

      ux_q  <= ux_d;
      uy_q  <= uy_d;
      a_q   <= a_d;
      y_q   <= y_d;
      fx2_q <= ux_q[31:16];
      fy2_q <= uy_q[31:16];
      w2x_q <= w2x_d;
      w2y_q <= w2y_d;
      a3_q  <= a_q;
      b_q   <= b_d;
      wt_q[0] <= wt_d;
      for (int s = 1; s < 5; s++) begin
        wt_q[s] <= wt_q[s-1];
      end
      h_q   <= h_d;
      g_q   <= g_d;
      d_q   <= d_d;
      pt_q  <= pt_d;
      pb_q  <= pb_d;
      d0_q  <= d_q[0];
      d2_q  <= d_q[2];
      top_q <= top_d;
      pv_q  <= pv_d;
      cv_q  <= cv_d;
    end
  end

  assign valid_o = vld_q[PN2_CELL_LAT-1];
  assign side_o  = side_q[PN2_CELL_LAT-1];

endmodule

>>> rtl/core/pn2_norm.sv
// Output stage: scales the octave sum by the amplitude reciprocal and saturates.
module pn2_norm import pn2_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [PN2_TOT_W-1:0] total_i,
  input  logic [19:0]                 recip_i,
  input  logic                        ready_i,
  output logic                        valid_o,
  output logic signed [15:0]          noise_o,
  output logic                        adv_o
);

  logic                              va_q, vo_q, out_load;
  logic signed [PN2_TOT_W+20:0]      prod_q, prod_d;
  logic signed [PN2_TOT_W-12:0]      res;
  logic signed [15:0]                sat, noise_q;

  // The output register loads when empty or taken; the chain behind it may
  // also move whenever the multiply stage holds a bubble.
  assign out_load = !vo_q || ready_i;
  assign adv_o    = out_load || !va_q;

  always_comb begin
    prod_d = total_i * $signed({1'b0, recip_i});
    res    = prod_q[PN2_TOT_W+20:32];
    if (res > 32767) begin
      sat = 16'sh7FFF;
    end else if (res < -32768) begin
      sat = -16'sh8000;
    end else begin
      sat = 16'(res);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (adv_o) begin
        va_q <= valid_i;
      end
      if (out_load) begin
        vo_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      prod_q <= prod_d;
    end
    if (out_load) begin
      noise_q <= sat;
    end
  end

  assign valid_o = vo_q;
  assign noise_o = noise_q;

endmodule

>>> rtl/core/perlin_noise_2d_octaves.sv
// Top level of the multi-octave 2D gradient noise generator.
//
//  Channel   Direction  Payload                     Meaning
//  point_i   in         point_x, point_y (Q16.16)    one sample request
//  noise_o   out        noise_value (Q1.15)          one noise result per request
//  cfg_i     in         index (3 bits), data (32)    register write, always ready
//
// One request is accepted every cycle while point_i.ready is high. A request
// passes MAX_OCTAVES octave cells, each a ten-stage pipeline, then a multiply
// stage and the output register. Reset clears only the valid bits and restores
// the register defaults. When the output is held, the chain still moves while
// the multiply stage in front of the output register is empty; once that stage
// holds a request, point_i.ready drops and the whole chain waits.
`include "perlin_noise_2d_octaves_macros.svh"

module perlin_noise_2d_octaves import pn2_pkg::*; #(
  parameter int unsigned MAX_OCTAVES = PN2_MAX_OCTAVES,
  parameter int unsigned ANGLE_BITS  = PN2_ANGLE_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pn2_point_if.sink    point_i,
  pn2_noise_if.source  noise_o,
  pn2_cfg_if.sink      cfg_i
);

  localparam int unsigned LAT  = MAX_OCTAVES * PN2_CELL_LAT + 2;
  localparam int unsigned FL_W = $clog2(LAT + 2);

  pn2_cfg_t  cfg_q;
  logic      adv;
  logic      cvld [MAX_OCTAVES+1];
  pn2_side_t cside [MAX_OCTAVES+1];

  // Register writes; software changes these only while the block is idle, which the block itself does not enforce.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mult1      <= 32'd1;
      cfg_q.mult2      <= 32'd1;
      cfg_q.mult3      <= 32'd1;
      cfg_q.base_freq  <= 24'd65536;
      cfg_q.freq_ratio <= 16'd8192;
      cfg_q.amp_ratio  <= 16'd32768;
      cfg_q.oct_cnt    <= 4'd1;
      cfg_q.amp_recip  <= 20'd65536;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_MULT1:      cfg_q.mult1      <= cfg_i.data;
        REG_MULT2:      cfg_q.mult2      <= cfg_i.data;
        REG_MULT3:      cfg_q.mult3      <= cfg_i.data;
        REG_BASE_FREQ:  cfg_q.base_freq  <= cfg_i.data[23:0];
        REG_FREQ_RATIO: cfg_q.freq_ratio <= cfg_i.data[15:0];
        REG_AMP_RATIO:  cfg_q.amp_ratio  <= cfg_i.data[15:0];
        REG_OCT_COUNT:  cfg_q.oct_cnt    <= cfg_i.data[3:0];
        REG_AMP_RECIP:  cfg_q.amp_recip  <= cfg_i.data[19:0];
        default: ;
      endcase
    end
  end

  // The first cell sees the raw point with unit amplitude and the base
  // frequency; every cell hands the next one its scaled frequency and amplitude.
  assign point_i.ready = adv;
  assign cvld[0]       = point_i.valid;
  always_comb begin
    cside[0].px    = point_i.point_x;
    cside[0].py    = point_i.point_y;
    cside[0].freq  = cfg_q.base_freq;
    cside[0].amp   = AMP_ONE;
    cside[0].total = '0;
  end

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_cell
    pn2_cell #(
      .ANGLE_BITS (ANGLE_BITS),
      .OCT_IDX    (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .cfg_i   (cfg_q),
      .valid_i (cvld[k]),
      .side_i  (cside[k]),
      .valid_o (cvld[k+1]),
      .side_o  (cside[k+1])
    );
  end

  pn2_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cvld[MAX_OCTAVES]),
    .total_i (cside[MAX_OCTAVES].total),
    .recip_i (cfg_q.amp_recip),
    .ready_i (noise_o.ready),
    .valid_o (noise_o.valid),
    .noise_o (noise_o.noise_value),
    .adv_o   (adv)
  );

  // Requests in flight, for checking only.
  logic [FL_W-1:0] flight_q, flight_d;
  logic            acc, del;

  assign acc = point_i.valid && point_i.ready;
  assign del = noise_o.valid && noise_o.ready;

  always_comb begin
    case ({acc, del})
      2'b10:   flight_d = flight_q + 1'b1;
      2'b01:   flight_d = flight_q - 1'b1;
      default: flight_d = flight_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flight_q <= '0;
    end else begin
      flight_q <= flight_d;
    end
  end

  // A request is refused only while a finished result sits unclaimed.
  `PN2_ASSERT_IMP(a_stall_cause, !point_i.ready, noise_o.valid && !noise_o.ready)
  // No result without a request behind it.
  `PN2_ASSERT_IMP(a_no_phantom, flight_q == '0, !noise_o.valid)
  // An accepted request is counted as in flight on the next cycle.
  `PN2_ASSERT_NXT(a_flight_count, acc, flight_q != '0)

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the multi-octave 2D gradient noise generator.
module testbench;
  import pn2_pkg::*;

  localparam int unsigned LATENCY   = 10 * PN2_MAX_OCTAVES + 2;
  localparam int unsigned NUM_RAND  = 500;
  localparam longint      MAX_CYCLES = 400000;

  logic clk_i;
  logic rst_ni;

  pn2_point_if point_bus ();
  pn2_noise_if noise_bus ();
  pn2_cfg_if   cfg_bus ();

  perlin_noise_2d_octaves uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .point_i (point_bus.sink),
    .noise_o (noise_bus.source),
    .cfg_i   (cfg_bus.sink)
  );

  // Register shadow used by the noise predictor.
  logic [31:0] mult_a, mult_b, mult_c;
  logic [23:0] base_freq;
  logic [15:0] freq_ratio, amp_ratio;
  logic [3:0]  oct_count;
  logic [19:0] amp_recip;
  logic [31:0] grad_rom [256];

  logic signed [15:0] noise_queue [$];
  bit      failed;
  longint  cycle_count;
  bit      stall_enable;

  function automatic int round_q15(longint v);
    longint r;
    if (v < 0) v = 0;
    r = (v + 16384) >>> 15;
    return (r > 32767) ? 32767 : int'(r);
  endfunction

  // Taylor series on one octant, returning cos and sin in Q1.15.
  function automatic void octant_trig(longint unsigned r, output int c, output int s);
    longint unsigned t, t2, t3, t4, t5, t6, t7, t8;
    t  = r * 64'd102944;
    t2 = (t * t) >> 30;
    t3 = (t2 * t) >> 30;
    t4 = (t2 * t2) >> 30;
    t5 = (t4 * t) >> 30;
    t6 = (t4 * t2) >> 30;
    t7 = (t6 * t) >> 30;
    t8 = (t4 * t4) >> 30;
    s = round_q15(longint'(t) - longint'(t3 / 6) + longint'(t5 / 120) - longint'(t7 / 5040));
    c = round_q15(64'sd1073741824 - longint'(t2 / 2) + longint'(t4 / 24)
                  - longint'(t6 / 720) + longint'(t8 / 40320));
  endfunction

  task automatic build_gradients();
    int unsigned p, q, r;
    int c, s, oc, os;
    for (int k = 0; k < 256; k++) begin
      p = (k << (16 - PN2_ANGLE_BITS)) & 16'hFFFF;
      q = p >> 14;
      r = p & 16'h3FFF;
      if (r > 8192) octant_trig(16384 - r, s, c);
      else octant_trig(r, c, s);
      case (q)
        0: begin oc = c;  os = s;  end
        1: begin oc = -s; os = c;  end
        2: begin oc = -c; os = -s; end
        default: begin oc = s; os = -c; end
      endcase
      grad_rom[k] = {oc[15:0], os[15:0]};
    end
  endtask

  function automatic longint floor_div(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint corner_dot(logic [31:0] cx, logic [31:0] cy,
                                         longint dx, longint dy);
    logic [31:0] a, b, g;
    a = cx * mult_a;
    b = cy ^ {a[15:0], a[31:16]};
    b = b * mult_b;
    a = a ^ {b[15:0], b[31:16]};
    a = a * mult_c;
    g = grad_rom[a[31:32-PN2_ANGLE_BITS]];
    return dx * longint'($signed(g[31:16])) + dy * longint'($signed(g[15:0]));
  endfunction

  function automatic longint smooth_weight(longint w);
    longint w2;
    w2 = (w * w) >> 16;
    return ((196608 - 2 * w) * w2) >> 16;
  endfunction

  function automatic longint lerp(longint a0, longint a1, longint s);
    return a0 + floor_div((a1 - a0) * s, 16);
  endfunction

  function automatic logic signed [15:0] predict_noise(logic signed [31:0] px,
                                                      logic signed [31:0] py);
    longint freq, amp, total, res, ux, uy, dx0, dy0, dx1, dy1, sx, sy, top, bot, v;
    int unsigned n;
    logic [31:0] x0, y0;
    freq  = base_freq;
    amp   = 65536;
    total = 0;
    n = (oct_count > PN2_MAX_OCTAVES) ? PN2_MAX_OCTAVES : oct_count;
    for (int i = 0; i < n; i++) begin
      ux  = longint'(px) * freq;
      uy  = longint'(py) * freq;
      x0  = ux[63:32];
      y0  = uy[63:32];
      dx0 = ux[31:16];
      dy0 = uy[31:16];
      dx1 = dx0 - 65536;
      dy1 = dy0 - 65536;
      sx  = smooth_weight(dx0);
      sy  = smooth_weight(dy0);
      top = lerp(corner_dot(x0, y0, dx0, dy0), corner_dot(x0 + 1, y0, dx1, dy0), sx);
      bot = lerp(corner_dot(x0, y0 + 1, dx0, dy1), corner_dot(x0 + 1, y0 + 1, dx1, dy1), sx);
      v   = lerp(top, bot, sy);
      total += floor_div(v * amp, 16);
      freq = (freq * freq_ratio) >> 12;
      if (freq > 24'hFFFFFF) freq = 24'hFFFFFF;
      amp = (amp * amp_ratio) >> 16;
    end
    res = floor_div(total * longint'(amp_recip), 32);
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return res[15:0];
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Cycle limit guards against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random backpressure, compare with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_bus.ready <= 1'b0;
    end else begin
      if (noise_bus.valid && noise_bus.ready) begin
        if (noise_queue.size() == 0) begin
          $display("%0t: unexpected noise result %0d", $time, noise_bus.noise_value);
          failed = 1'b1;
        end else begin
          if (noise_bus.noise_value !== noise_queue[0]) begin
            $display("%0t: noise_value expected %0d actual %0d", $time,
                     noise_queue[0], noise_bus.noise_value);
            failed = 1'b1;
          end
          void'(noise_queue.pop_front());
        end
      end
      if (!stall_enable) noise_bus.ready <= 1'b1;
      else if ($urandom_range(0, 99) < 3) noise_bus.ready <= 1'b0;
      else if ($urandom_range(0, 99) < 40) noise_bus.ready <= 1'b1;
    end
  end

  // Ready is sampled mid-cycle, where it holds the value seen at the next edge.
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    bit rdy;
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do begin
      @(negedge clk_i);
      rdy = cfg_bus.ready;
      @(posedge clk_i);
    end while (!rdy);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_MULT1:      mult_a     = value;
      REG_MULT2:      mult_b     = value;
      REG_MULT3:      mult_c     = value;
      REG_BASE_FREQ:  base_freq  = value[23:0];
      REG_FREQ_RATIO: freq_ratio = value[15:0];
      REG_AMP_RATIO:  amp_ratio  = value[15:0];
      REG_OCT_COUNT:  oct_count  = value[3:0];
      REG_AMP_RECIP:  amp_recip  = value[19:0];
      default: ;
    endcase
  endtask

  // Sends one point request; a random gap may come first.
  task automatic send_point(logic signed [31:0] px, logic signed [31:0] py);
    int gap;
    bit rdy;
    if (stall_enable && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      point_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    point_bus.valid   <= 1'b1;
    point_bus.point_x <= px;
    point_bus.point_y <= py;
    do begin
      @(negedge clk_i);
      rdy = point_bus.ready;
      @(posedge clk_i);
    end while (!rdy);
    noise_queue.push_back(predict_noise(px, py));
  endtask

  task automatic drain();
    point_bus.valid <= 1'b0;
    while (noise_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic random_config(bit extreme);
    write_reg(REG_MULT1, $urandom());
    write_reg(REG_MULT2, $urandom());
    write_reg(REG_MULT3, $urandom());
    write_reg(REG_BASE_FREQ, extreme ? 32'hFFFFFF : $urandom_range(0, 24'h3FFFF));
    write_reg(REG_FREQ_RATIO, extreme ? 32'hFFFF : $urandom_range(0, 16'h4000));
    write_reg(REG_AMP_RATIO, extreme ? 32'hFFFF : $urandom_range(0, 16'hFFFF));
    write_reg(REG_OCT_COUNT, extreme ? 15 : $urandom_range(0, 15));
    write_reg(REG_AMP_RECIP, extreme ? 32'hFFFFF : $urandom_range(0, 20'hFFFFF));
  endtask

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    bit                 known;
    logic signed [15:0] noise;
  } point_row_t;

  point_row_t directed_rows [] = '{
    // A lattice point gives zero offsets, so the noise is exactly zero.
    '{32'sd0, 32'sd0, 1'b1, 16'sd0},
    '{32'sh0001_0000, 32'sh0003_0000, 1'b1, 16'sd0},
    '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 16'sd0},
    '{32'sh8000_0000, 32'sh8000_0000, 1'b1, 16'sd0},
    '{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 16'sd0},
    '{32'sh0000_8000, 32'sh0000_8000, 1'b0, 16'sd0},
    '{-32'sd1, -32'sd1, 1'b0, 16'sd0},
    '{32'sh0000_FFFF, 32'sh0000_0001, 1'b0, 16'sd0},
    '{32'sh1234_5678, -32'sh0ABC_DEF0, 1'b0, 16'sd0},
    '{32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, 16'sd0}
  };

  initial begin
    logic signed [31:0] rx, ry;
    failed       = 1'b0;
    cycle_count  = 0;
    stall_enable = 1'b0;
    rst_ni       = 1'b0;
    point_bus.valid   <= 1'b0;
    point_bus.point_x <= '0;
    point_bus.point_y <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_MULT1;
    cfg_bus.data  <= '0;
    mult_a = 1; mult_b = 1; mult_c = 1;
    base_freq = 24'd65536; freq_ratio = 16'd8192; amp_ratio = 16'd32768;
    oct_count = 4'd1; amp_recip = 20'd65536;
    build_gradients();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at the reset settings, then at the extreme settings.
    foreach (directed_rows[i]) begin
      send_point(directed_rows[i].px, directed_rows[i].py);
      if (directed_rows[i].known && noise_queue[$] !== directed_rows[i].noise) begin
        $display("%0t: table row %0d expected %0d actual %0d", $time, i,
                 directed_rows[i].noise, noise_queue[$]);
        failed = 1'b1;
      end
    end
    drain();
    random_config(1'b1);
    foreach (directed_rows[i]) send_point(directed_rows[i].px, directed_rows[i].py);
    drain();
    // Zero octaves and zero reciprocal both force the output to zero.
    write_reg(REG_OCT_COUNT, 0);
    send_point(32'sh0001_8000, 32'sh0002_4000);
    drain();
    write_reg(REG_OCT_COUNT, 8);
    write_reg(REG_AMP_RECIP, 0);
    send_point(32'sh0001_8000, 32'sh0002_4000);
    drain();

    // Random phases with fresh settings, idling on both sides.
    stall_enable = 1'b1;
    for (int phase = 0; phase < 5; phase++) begin
      random_config(1'b0);
      for (int k = 0; k < NUM_RAND / 5; k++) begin
        rx = $urandom();
        ry = $urandom();
        if ($urandom_range(0, 2) != 0) begin
          rx = $signed(rx) >>> $urandom_range(0, 24);
          ry = $signed(ry) >>> $urandom_range(0, 24);
        end
        // Stretches without gaps exercise back-to-back acceptance.
        stall_enable = (k % 40) >= 10;
        send_point(rx, ry);
      end
      drain();
    end

    if (!failed) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
